### rtl/pad_charge_erf_spread_macros.svh
// ----------------------------------------------------------------------------
// Pad charge erf spread: assertion macros
// Concurrent assertion wrappers; the block form is clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAD_CHARGE_ERF_SPREAD_MACROS_SVH
`define PAD_CHARGE_ERF_SPREAD_MACROS_SVH

// explicit clock and reset
`define PCES_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("pad charge check failed");

// block clock and reset
`define PCES_ASSERT(lbl, prop) `PCES_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

### rtl/pces_pkg.sv
// ----------------------------------------------------------------------------
// Pad charge erf spread: package
// Widths, pipeline depth, register indexes and the erf table built at
// elaboration.
// ----------------------------------------------------------------------------
package pces_pkg;

  // field widths
  localparam int TIME_W    = 24;
  localparam int POS_W     = 21;
  localparam int D_W       = POS_W + 1;
  localparam int AD_W      = POS_W;
  localparam int RATE_W    = 32;
  localparam int WSQ_W     = 24;
  localparam int NORM_W    = 32;
  localparam int OUT_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SQUARED  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_NORM    = CFG_IDX_W'(2);

  // erf table
  localparam int ERF_TABLE_DEPTH = 1024;
  localparam int ERF_FRAC_BITS   = 16;
  localparam int DEPTH_BITS      = $clog2(ERF_TABLE_DEPTH);
  localparam int ERF_W           = ERF_FRAC_BITS + 1;
  localparam int PAIR_W          = 2 * ERF_W;
  localparam int FILL_W          = DEPTH_BITS + 1;
  localparam logic [ERF_W-1:0] ERF_ONE = ERF_W'(1) << ERF_FRAC_BITS;

  // spread and square root
  localparam int VAR_W    = TIME_W + RATE_W + 1;
  localparam int SQ_W     = 64;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROOT_W   = 31;
  localparam int SQ_PRE   = 5;

  // index division: quotient is the table position in Q.16
  localparam int POS_FRAC = 16;
  localparam int QB       = POS_FRAC + DEPTH_BITS;
  localparam int REM_SH   = 8;

  // charge product
  localparam int EE_W  = ERF_W + 1;
  localparam int ED_W  = EE_W + 1;
  localparam int MD_W  = ERF_W + 1;
  localparam int P1_W  = MD_W + NORM_W;
  localparam int PL_W  = 32 + AD_W;
  localparam int PH_W  = P1_W - 32;
  localparam int PHP_W = PH_W + AD_W;
  localparam int SUM_W = P1_W + AD_W + 1;
  localparam int SHIFT = ERF_FRAC_BITS + 24;
  localparam int MAG_W = SUM_W - SHIFT;
  localparam int PR_W  = ERF_W + POS_FRAC + 1;

  // input, spread, root steps, prep, divide steps, read, interp, diff,
  // two multiplies, output
  localparam int PIPE_DEPTH = 2 + SQ_STEPS + 1 + QB + 6;

  typedef struct packed {
    logic            late;
    logic [D_W-1:0]  dh;
    logic [D_W-1:0]  dl;
    logic [D_W-1:0]  dx;
  } carry_t;

  typedef struct packed {
    logic            late;
    logic [D_W-1:0]  dx;
  } tail_t;

  typedef struct packed {
    logic neg;
    logic nil;
    logic sat;
  } off_t;

  // table construction, Q58 fixed point
  localparam int unsigned FIX_Q    = 58;
  localparam int          SUBSTEPS = 16;
  localparam logic [63:0] FIX_ONE  = 64'd1 << FIX_Q;
  localparam logic [63:0] TWO_OVER_SQRTPI_Q32 = 64'd4846351620;
  localparam logic [63:0] TAB_D  = 64'(ERF_TABLE_DEPTH);
  localparam logic [63:0] TAB_DD = TAB_D * TAB_D;
  localparam logic [63:0] TAB_U  = ((64'd1 << 54) + TAB_DD / 2) / TAB_DD;
  localparam logic [63:0] TAB_DIV = 64'd12 * TAB_D;
  localparam logic [63:0] TAB_BIAS = 64'd6 * TAB_D;

  typedef logic [ERF_W-1:0] erf_tab_t [ERF_TABLE_DEPTH+1];

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic erf_tab_t build_erf_table();
    erf_tab_t    t;
    logic [63:0] e, term, r, q, g, integ, sum, v;
    e     = FIX_ONE;
    term  = FIX_ONE;
    g     = FIX_ONE;
    integ = '0;
    for (int n = 1; n < 24; n++) begin
      term = mul_shr(term, TAB_U, FIX_Q) / 64'(n);
      if ((n & 1) != 0) e = e - term;
      else              e = e + term;
    end
    r = e;
    q = mul_shr(e, e, FIX_Q);
    t[0] = '0;
    for (int k = 0; k < ERF_TABLE_DEPTH; k++) begin
      sum = g;
      for (int m = 1; m <= SUBSTEPS; m++) begin
        g = mul_shr(g, r, FIX_Q);
        r = mul_shr(r, q, FIX_Q);
        if (m == SUBSTEPS)      sum = sum + g;
        else if ((m & 1) != 0)  sum = sum + 64'd4 * g;
        else                    sum = sum + 64'd2 * g;
      end
      integ = integ + (sum + TAB_BIAS) / TAB_DIV;
      v = mul_shr(integ, TWO_OVER_SQRTPI_Q32, 32);
      v = (v + (64'd1 << (FIX_Q - 1 - ERF_FRAC_BITS))) >> (FIX_Q - ERF_FRAC_BITS);
      if (v > (64'd1 << ERF_FRAC_BITS)) v = 64'd1 << ERF_FRAC_BITS;
      t[k+1] = v[ERF_W-1:0];
    end
    return t;
  endfunction

  localparam erf_tab_t ERF_TAB = build_erf_table();

endpackage

### rtl/pces_ram.sv
// ----------------------------------------------------------------------------
// Pad charge erf spread: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pces_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pad_charge_erf_spread.sv
// ----------------------------------------------------------------------------
// Pad charge erf spread: top level
// Charge collected by one pad from a diffusing point deposit, using an
// interpolated erf table and a fully pipelined root and divide.
// ----------------------------------------------------------------------------
// channel   ports                      handshake
// request   start, in_*                taken when start && !busy
// result    out_valid, out_pad_charge  one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_*   written when cfg_we is high
//
// One request per cycle while busy is low; the pipeline holds 32 root steps and
// 26 divide steps, one per stage, between a request and its result.
// After reset the erf table RAMs are loaded with busy high;
// config writes are taken during that time.
// The result side has no stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module pad_charge_erf_spread import pces_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic [TIME_W-1:0]        in_deposit_time,
  input  logic signed [POS_W-1:0]  in_track_y,
  input  logic signed [POS_W-1:0]  in_pad_x_low,
  input  logic signed [POS_W-1:0]  in_pad_x_high,
  input  logic signed [POS_W-1:0]  in_pad_y_low,
  input  logic signed [POS_W-1:0]  in_pad_y_high,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_pad_charge,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  // --------------------------------------------------------------------------
  // configuration
  logic [RATE_W-1:0] diffusion_rate_r;
  logic [WSQ_W-1:0]  width_squared_r;
  logic [NORM_W-1:0] charge_norm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diffusion_rate_r <= '0;
      width_squared_r  <= '0;
      charge_norm_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFFUSION_RATE: diffusion_rate_r <= cfg_wdata[RATE_W-1:0];
        REG_WIDTH_SQUARED:  width_squared_r  <= cfg_wdata[WSQ_W-1:0];
        REG_CHARGE_NORM:    charge_norm_r    <= cfg_wdata[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // table load: RAM entry k holds {t[k+1], t[k]}
  logic              fill_r;
  logic [FILL_W-1:0] fill_cnt_r;
  logic [ERF_W-1:0]  fill_prev_r;
  logic [ERF_W-1:0]  fill_cur;
  logic              fill_we;
  logic [FILL_W-1:0] fill_addr;

  assign fill_cur  = ERF_TAB[fill_cnt_r];
  assign fill_we   = fill_r && (fill_cnt_r != '0);
  assign fill_addr = fill_cnt_r - FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= 1'b1;
      fill_cnt_r <= '0;
    end else if (fill_r) begin
      fill_cnt_r <= fill_cnt_r + FILL_W'(1);
      if (fill_cnt_r == FILL_W'(ERF_TABLE_DEPTH)) fill_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fill_prev_r <= fill_cur;
  end

  assign busy = fill_r;

  logic accept;
  assign accept = start && !busy;

  // valid bits, one per stage
  logic [PIPE_DEPTH-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[PIPE_DEPTH-2:0], accept};
  end

  // --------------------------------------------------------------------------
  // stage A: elapsed time and offsets
  logic [TIME_W:0]   el_nxt;
  logic [TIME_W-1:0] a_el_r;
  carry_t            a_c_r;
  carry_t            a_c_nxt;

  assign el_nxt = {1'b0, in_sample_time} - {1'b0, in_deposit_time};

  always_comb begin
    a_c_nxt.late = el_nxt[TIME_W] || (el_nxt == '0);
    a_c_nxt.dh   = {in_pad_y_high[POS_W-1], in_pad_y_high} - {in_track_y[POS_W-1], in_track_y};
    a_c_nxt.dl   = {in_pad_y_low[POS_W-1], in_pad_y_low} - {in_track_y[POS_W-1], in_track_y};
    a_c_nxt.dx   = {in_pad_x_high[POS_W-1], in_pad_x_high}
                   - {in_pad_x_low[POS_W-1], in_pad_x_low};
  end

  always_ff @(posedge clk) begin
    a_el_r <= el_nxt[TIME_W-1:0];
    a_c_r  <= a_c_nxt;
  end

  // stage B: variance in Q41.16
  logic [TIME_W+RATE_W-1:0] b_prod;
  logic [VAR_W-1:0]         b_var_nxt;
  logic [VAR_W-1:0]         b_var_r;
  carry_t                   b_c_r;

  assign b_prod    = a_el_r * diffusion_rate_r;
  assign b_var_nxt = VAR_W'(b_prod) + VAR_W'({width_squared_r, 16'b0});

  always_ff @(posedge clk) begin
    b_var_r <= b_var_nxt;
    b_c_r   <= a_c_r;
  end

  // --------------------------------------------------------------------------
  // square root, one result bit per stage
  logic [SQ_W-1:0] sq_x_r     [SQ_STEPS];
  logic [SQ_W-1:0] sq_res_r   [SQ_STEPS];
  logic [SQ_W-1:0] sq_x_nxt   [SQ_STEPS];
  logic [SQ_W-1:0] sq_res_nxt [SQ_STEPS];
  carry_t          sq_c_r     [SQ_STEPS];

  always_comb begin
    logic [SQ_W-1:0] xi, ri, bv, tr;
    for (int j = 0; j < SQ_STEPS; j++) begin
      if (j == 0) begin
        xi = SQ_W'(b_var_r) << SQ_PRE;
        ri = '0;
      end else begin
        xi = sq_x_r[j-1];
        ri = sq_res_r[j-1];
      end
      bv = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
      tr = ri + bv;
      if (xi >= tr) begin
        sq_x_nxt[j]   = xi - tr;
        sq_res_nxt[j] = (ri >> 1) + bv;
      end else begin
        sq_x_nxt[j]   = xi;
        sq_res_nxt[j] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      sq_x_r[j]   <= sq_x_nxt[j];
      sq_res_r[j] <= sq_res_nxt[j];
      sq_c_r[j]   <= (j == 0) ? b_c_r : sq_c_r[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // prep: magnitudes, far-tail and zero flags, divider seed
  function automatic logic [AD_W-1:0] abs_d(input logic [D_W-1:0] d);
    logic [D_W-1:0] t;
    t = d[D_W-1] ? (~d + D_W'(1)) : d;
    return t[AD_W-1:0];
  endfunction

  logic [ROOT_W-1:0] root_nxt;
  logic [AD_W-1:0]   ah, al;
  logic [ROOT_W-1:0] seed_h, seed_l;
  off_t              fh_nxt, fl_nxt;

  assign root_nxt = sq_res_r[SQ_STEPS-1][ROOT_W-1:0];
  assign ah       = abs_d(sq_c_r[SQ_STEPS-1].dh);
  assign al       = abs_d(sq_c_r[SQ_STEPS-1].dl);
  assign seed_h   = ROOT_W'({ah, REM_SH'(0)});
  assign seed_l   = ROOT_W'({al, REM_SH'(0)});

  always_comb begin
    fh_nxt.neg = sq_c_r[SQ_STEPS-1].dh[D_W-1];
    fh_nxt.nil = (ah == '0);
    fh_nxt.sat = (seed_h >= root_nxt);
    fl_nxt.neg = sq_c_r[SQ_STEPS-1].dl[D_W-1];
    fl_nxt.nil = (al == '0);
    fl_nxt.sat = (seed_l >= root_nxt);
  end

  logic [ROOT_W-1:0] p_root_r, p_rem_h_r, p_rem_l_r;
  off_t              p_fh_r, p_fl_r;
  tail_t             p_t_r;

  always_ff @(posedge clk) begin
    p_root_r   <= root_nxt;
    p_rem_h_r  <= seed_h;
    p_rem_l_r  <= seed_l;
    p_fh_r     <= fh_nxt;
    p_fl_r     <= fl_nxt;
    p_t_r.late <= sq_c_r[SQ_STEPS-1].late;
    p_t_r.dx   <= sq_c_r[SQ_STEPS-1].dx;
  end

  // --------------------------------------------------------------------------
  // table position = (|d| << 34) / root, one quotient bit per stage
  logic [ROOT_W-1:0] dv_root_r    [QB];
  logic [ROOT_W-1:0] dv_rem_h_r   [QB];
  logic [ROOT_W-1:0] dv_rem_l_r   [QB];
  logic [QB-1:0]     dv_q_h_r     [QB];
  logic [QB-1:0]     dv_q_l_r     [QB];
  logic [ROOT_W-1:0] dv_rem_h_nxt [QB];
  logic [ROOT_W-1:0] dv_rem_l_nxt [QB];
  logic [QB-1:0]     dv_q_h_nxt   [QB];
  logic [QB-1:0]     dv_q_l_nxt   [QB];
  off_t              dv_fh_r      [QB];
  off_t              dv_fl_r      [QB];
  tail_t             dv_t_r       [QB];

  always_comb begin
    logic [ROOT_W-1:0] rt, rh, rl;
    logic [QB-1:0]     qh, ql;
    logic [ROOT_W:0]   sh, sl;
    for (int j = 0; j < QB; j++) begin
      if (j == 0) begin
        rt = p_root_r;
        rh = p_rem_h_r;
        rl = p_rem_l_r;
        qh = '0;
        ql = '0;
      end else begin
        rt = dv_root_r[j-1];
        rh = dv_rem_h_r[j-1];
        rl = dv_rem_l_r[j-1];
        qh = dv_q_h_r[j-1];
        ql = dv_q_l_r[j-1];
      end
      sh = {rh, 1'b0};
      sl = {rl, 1'b0};
      if (sh >= {1'b0, rt}) begin
        dv_rem_h_nxt[j] = ROOT_W'(sh - {1'b0, rt});
        dv_q_h_nxt[j]   = {qh[QB-2:0], 1'b1};
      end else begin
        dv_rem_h_nxt[j] = sh[ROOT_W-1:0];
        dv_q_h_nxt[j]   = {qh[QB-2:0], 1'b0};
      end
      if (sl >= {1'b0, rt}) begin
        dv_rem_l_nxt[j] = ROOT_W'(sl - {1'b0, rt});
        dv_q_l_nxt[j]   = {ql[QB-2:0], 1'b1};
      end else begin
        dv_rem_l_nxt[j] = sl[ROOT_W-1:0];
        dv_q_l_nxt[j]   = {ql[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QB; j++) begin
      dv_rem_h_r[j] <= dv_rem_h_nxt[j];
      dv_rem_l_r[j] <= dv_rem_l_nxt[j];
      dv_q_h_r[j]   <= dv_q_h_nxt[j];
      dv_q_l_r[j]   <= dv_q_l_nxt[j];
      dv_root_r[j]  <= (j == 0) ? p_root_r : dv_root_r[j-1];
      dv_fh_r[j]    <= (j == 0) ? p_fh_r   : dv_fh_r[j-1];
      dv_fl_r[j]    <= (j == 0) ? p_fl_r   : dv_fl_r[j-1];
      dv_t_r[j]     <= (j == 0) ? p_t_r    : dv_t_r[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // table read, one RAM per offset
  logic [PAIR_W-1:0]     rd_h, rd_l;
  logic [DEPTH_BITS-1:0] rd_addr_h, rd_addr_l;
  logic [PAIR_W-1:0]     fill_data;

  assign rd_addr_h = dv_q_h_r[QB-1][QB-1 -: DEPTH_BITS];
  assign rd_addr_l = dv_q_l_r[QB-1][QB-1 -: DEPTH_BITS];
  assign fill_data = {fill_cur, fill_prev_r};

  pces_ram #(.WIDTH(PAIR_W), .DEPTH(ERF_TABLE_DEPTH)) u_ram_h (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_addr[DEPTH_BITS-1:0]),
    .wr_data (fill_data),
    .rd_addr (rd_addr_h),
    .rd_data (rd_h)
  );

  pces_ram #(.WIDTH(PAIR_W), .DEPTH(ERF_TABLE_DEPTH)) u_ram_l (
    .clk     (clk),
    .wr_en   (fill_we),
    .wr_addr (fill_addr[DEPTH_BITS-1:0]),
    .wr_data (fill_data),
    .rd_addr (rd_addr_l),
    .rd_data (rd_l)
  );

  logic [POS_FRAC-1:0] r_frac_h_r, r_frac_l_r;
  off_t                r_fh_r, r_fl_r;
  tail_t               r_t_r;

  always_ff @(posedge clk) begin
    r_frac_h_r <= dv_q_h_r[QB-1][POS_FRAC-1:0];
    r_frac_l_r <= dv_q_l_r[QB-1][POS_FRAC-1:0];
    r_fh_r     <= dv_fh_r[QB-1];
    r_fl_r     <= dv_fl_r[QB-1];
    r_t_r      <= dv_t_r[QB-1];
  end

  // --------------------------------------------------------------------------
  // interpolation and sign
  function automatic logic [EE_W-1:0] erf_val(input logic [PAIR_W-1:0] pair,
                                              input logic [POS_FRAC-1:0] fr,
                                              input off_t f);
    logic [ERF_W-1:0] lo, hi, dlt, mag;
    logic [PR_W-1:0]  pr;
    lo  = pair[ERF_W-1:0];
    hi  = pair[PAIR_W-1:ERF_W];
    dlt = hi - lo;
    pr  = (PR_W'(dlt) * PR_W'(fr)) + (PR_W'(1) << (POS_FRAC - 1));
    mag = lo + ERF_W'(pr >> POS_FRAC);
    if (f.sat) mag = ERF_ONE;
    if (f.nil) return '0;
    else if (f.neg) return ~EE_W'(mag) + EE_W'(1);
    else return EE_W'(mag);
  endfunction

  logic [EE_W-1:0] i_eh_r, i_el_r;
  tail_t           i_t_r;

  always_ff @(posedge clk) begin
    i_eh_r <= erf_val(rd_h, r_frac_h_r, r_fh_r);
    i_el_r <= erf_val(rd_l, r_frac_l_r, r_fl_r);
    i_t_r  <= r_t_r;
  end

  // erf difference and pad length, as magnitudes and a sign
  logic [ED_W-1:0] ed_nxt, ed_abs;
  logic [D_W-1:0]  dx_abs;

  assign ed_nxt = {i_eh_r[EE_W-1], i_eh_r} - {i_el_r[EE_W-1], i_el_r};
  assign ed_abs = ed_nxt[ED_W-1] ? (~ed_nxt + ED_W'(1)) : ed_nxt;
  assign dx_abs = i_t_r.dx[D_W-1] ? (~i_t_r.dx + D_W'(1)) : i_t_r.dx;

  logic [MD_W-1:0] e_mdiff_r;
  logic [AD_W-1:0] e_mdx_r;
  logic            e_neg_r, e_late_r;

  always_ff @(posedge clk) begin
    e_mdiff_r <= ed_abs[MD_W-1:0];
    e_mdx_r   <= dx_abs[AD_W-1:0];
    e_neg_r   <= ed_nxt[ED_W-1] ^ i_t_r.dx[D_W-1];
    e_late_r  <= i_t_r.late;
  end

  // |ediff| * charge_norm
  logic [P1_W-1:0] m1_p_r;
  logic [AD_W-1:0] m1_mdx_r;
  logic            m1_neg_r, m1_late_r;

  always_ff @(posedge clk) begin
    m1_p_r    <= e_mdiff_r * charge_norm_r;
    m1_mdx_r  <= e_mdx_r;
    m1_neg_r  <= e_neg_r;
    m1_late_r <= e_late_r;
  end

  // times |dx|, in two partial products
  logic [PL_W-1:0]  m2_pl_r;
  logic [PHP_W-1:0] m2_ph_r;
  logic             m2_neg_r, m2_late_r;

  always_ff @(posedge clk) begin
    m2_pl_r   <= m1_p_r[31:0] * m1_mdx_r;
    m2_ph_r   <= m1_p_r[P1_W-1:32] * m1_mdx_r;
    m2_neg_r  <= m1_neg_r;
    m2_late_r <= m1_late_r;
  end

  // round, shift and sign; the magnitude stays far inside 48 bits
  logic [SUM_W-1:0] sum_nxt;
  logic [OUT_W-1:0] mag_ext, res_nxt, out_r;
  logic             out_valid_r;

  assign sum_nxt = SUM_W'(m2_pl_r) + (SUM_W'(m2_ph_r) << 32) + (SUM_W'(1) << (SHIFT - 1));
  assign mag_ext = OUT_W'(sum_nxt[SUM_W-1:SHIFT]);

  always_comb begin
    if (m2_late_r)     res_nxt = '0;
    else if (m2_neg_r) res_nxt = ~mag_ext + OUT_W'(1);
    else               res_nxt = mag_ext;
  end

  always_ff @(posedge clk) begin
    out_r <= res_nxt;
  end

  assign out_valid_r    = v_r[PIPE_DEPTH-1];
  assign out_valid      = out_valid_r;
  assign out_pad_charge = out_r;

endmodule

### rtl/pces_chk.sv
// ----------------------------------------------------------------------------
// Pad charge erf spread: port checker
// Watches the top level's ports for latency and busy behaviour.
// ----------------------------------------------------------------------------
`include "pad_charge_erf_spread_macros.svh"

module pces_chk import pces_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [TIME_W-1:0]       in_sample_time,
  input logic [TIME_W-1:0]       in_deposit_time,
  input logic signed [POS_W-1:0] in_track_y,
  input logic signed [POS_W-1:0] in_pad_x_low,
  input logic signed [POS_W-1:0] in_pad_x_high,
  input logic signed [POS_W-1:0] in_pad_y_low,
  input logic signed [POS_W-1:0] in_pad_y_high,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_pad_charge,
  input logic                    cfg_we,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [CFG_W-1:0]        cfg_wdata
);

  // table load happens once per reset
  `PCES_ASSERT(a_busy_stays_low, !busy |=> !busy)

  `PCES_ASSERT(a_no_result_while_loading, busy |-> !out_valid)

  // every result belongs to a request a fixed depth back
  `PCES_ASSERT(a_result_has_request, out_valid |-> $past(start && !busy, PIPE_DEPTH))

  `PCES_ASSERT(a_zero_before_deposit,
    (out_valid && $past(in_sample_time <= in_deposit_time, PIPE_DEPTH)) |-> (out_pad_charge == '0))

endmodule

bind pad_charge_erf_spread pces_chk u_pces_chk (.*);

### tb/pad_charge_erf_spread_test.sv
// ----------------------------------------------------------------------------
// Pad charge erf spread: testbench
// Drives pad requests under several register settings. Each result is
// checked against a stored expected value or a local fixed-point model of the erf spread.
// ----------------------------------------------------------------------------
module pad_charge_erf_spread_test import pces_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1530;

  typedef struct {
    logic [TIME_W-1:0]       st;
    logic [TIME_W-1:0]       dt;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] xl;
    logic signed [POS_W-1:0] xh;
    logic signed [POS_W-1:0] yl;
    logic signed [POS_W-1:0] yh;
    bit                      typed;
    logic [OUT_W-1:0]        want;
  } pad_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TIME_W-1:0] in_sample_time = '0, in_deposit_time = '0;
  logic signed [POS_W-1:0] in_track_y = '0, in_pad_x_low = '0, in_pad_x_high = '0;
  logic signed [POS_W-1:0] in_pad_y_low = '0, in_pad_y_high = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_pad_charge;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pad_charge_erf_spread dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copies of the registers and the erf table
  logic [63:0] m_rate, m_wsq, m_norm;
  logic [63:0] erf_lut [ERF_TABLE_DEPTH+1];
  logic [OUT_W-1:0] charge_q [$];
  int errors = 0;
  int cycles = 0;
  bit idling = 1'b1;

  function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) + (128'd1 << (s - 1));
    return p[63+s -: 64];
  endfunction

  function automatic void fill_lut();
    logic [63:0] ex, tm, r, q, g, acc, sum, v, stp;
    stp = ((64'd1 << 54) + 64'd524288) / 64'd1048576;
    ex = 64'd1 << 58; tm = ex; g = ex; acc = '0;
    for (int n = 1; n < 24; n++) begin
      tm = mulsh(tm, stp, 58) / 64'(n);
      ex = n[0] ? ex - tm : ex + tm;
    end
    r = ex;
    q = mulsh(ex, ex, 58);
    erf_lut[0] = '0;
    for (int k = 0; k < ERF_TABLE_DEPTH; k++) begin
      sum = g;
      for (int m = 1; m <= 16; m++) begin
        g = mulsh(g, r, 58);
        r = mulsh(r, q, 58);
        sum += (m == 16) ? g : (m[0] ? 4 * g : 2 * g);
      end
      acc += (sum + 64'd6144) / 64'd12288;
      v = mulsh(acc, 64'd4846351620, 32);
      v = (v + (64'd1 << 41)) >> 42;
      if (v > 64'd65536) v = 64'd65536;
      erf_lut[k+1] = v;
    end
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res, bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint erf_at(longint d, logic [63:0] root);
    logic [63:0] ad, mag, pos, idx, fr;
    if (d == 0) return 0;
    ad = (d < 0) ? -d : d;
    if ((ad << 8) >= root) begin
      mag = 64'd65536;
    end else begin
      pos = ((ad << 10) * ERF_TABLE_DEPTH << 16) / (root << 2);
      idx = pos >> 16;
      fr = pos & 64'hFFFF;
      if (idx >= ERF_TABLE_DEPTH) mag = 64'd65536;
      else mag = erf_lut[idx] + (((erf_lut[idx+1] - erf_lut[idx]) * fr + 64'h8000) >> 16);
    end
    return (d < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [OUT_W-1:0] pad_charge_of(pad_req_t r);
    longint el, ed, dx;
    logic [63:0] root, mag, lim;
    el = longint'(r.st) - longint'(r.dt);
    if (el <= 0) return '0;
    root = int_root((64'(el) * m_rate + (m_wsq << 16)) << 5);
    ed = erf_at(longint'(r.yh) - longint'(r.y), root)
       - erf_at(longint'(r.yl) - longint'(r.y), root);
    dx = longint'(r.xh) - longint'(r.xl);
    if (ed == 0 || dx == 0) return '0;
    mag = mulsh(64'(ed < 0 ? -ed : ed) * m_norm, 64'(dx < 0 ? -dx : dx), 40);
    lim = 64'd1 << 47;
    if ((ed < 0) != (dx < 0)) begin
      if (mag > lim) mag = lim;
      return OUT_W'(-mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return OUT_W'(mag);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_DIFFUSION_RATE: m_rate = 64'(val);
      REG_WIDTH_SQUARED:  m_wsq  = 64'(val[WSQ_W-1:0]);
      REG_CHARGE_NORM:    m_norm = 64'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [31:0] rate, logic [31:0] wsq, logic [31:0] norm);
    write_reg(REG_DIFFUSION_RATE, rate);
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_WIDTH_SQUARED, wsq);
    write_reg(REG_CHARGE_NORM, norm);
  endtask

  // wait for the pipe to empty before touching registers
  task automatic drain();
    start = 1'b0;
    while (charge_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic send(pad_req_t r);
    if (idling && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_sample_time = r.st; in_deposit_time = r.dt; in_track_y = r.y;
    in_pad_x_low = r.xl; in_pad_x_high = r.xh; in_pad_y_low = r.yl; in_pad_y_high = r.yh;
    start = 1'b1;
    do @(posedge clk); while (busy);
    charge_q.push_back(r.typed ? r.want : pad_charge_of(r));
    @(negedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] c);
    int span;
    span = 2 ** $urandom_range(0, 20);
    return POS_W'(int'(c) + $urandom_range(0, 2 * span) - span);
  endfunction

  function automatic pad_req_t rand_req();
    pad_req_t r;
    r.typed = 1'b0;
    r.want = '0;
    r.st = TIME_W'($urandom); r.dt = TIME_W'($urandom); r.y = POS_W'($urandom);
    r.xl = POS_W'($urandom); r.xh = POS_W'($urandom);
    r.yl = POS_W'($urandom); r.yh = POS_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      // plausible geometry: pad edges close to the deposit, time at or after it
      r.dt = TIME_W'($urandom_range(0, 24'h7FFFFF));
      r.st = TIME_W'(r.dt + (2 ** $urandom_range(0, 23)) - 1 + $urandom_range(0, 1));
      r.yl = near(r.y);
      r.yh = near(r.y);
      r.xh = near(r.xl);
    end
    return r;
  endfunction

  // far-edge pads with sigma about ten micrometres give erf difference two
  pad_req_t dir_tab [] = '{
    '{24'd5, 24'd5, 21'sd0, -21'sd100, 21'sd100, -21'sd50, 21'sd50, 1, 48'd0},
    '{24'd3, 24'hFFFFFF, 21'sd0, -21'sd100, 21'sd100, -21'sd50, 21'sd50, 1, 48'd0},
    '{24'hFFFFFF, 24'd0, 21'sd7, 21'sd0, 21'sd0, -21'sd50, 21'sd50, 1, 48'd0},
    '{24'd10, 24'd0, 21'sd9, 21'sd0, 21'sd900, 21'sd9, 21'sd9, 1, 48'd0},
    '{24'd1, 24'd0, 21'sd0, 21'sd0, 21'sd1000, -21'sd1048576, 21'sd1048575, 1, 48'd2000},
    '{24'd1, 24'd0, 21'sd0, 21'sd0, 21'sd1000, 21'sd1048575, -21'sd1048576, 1,
      -48'sd2000},
    '{24'd1, 24'd0, 21'sd0, 21'sd1000, 21'sd0, 21'sd1048575, -21'sd1048576, 1, 48'd2000},
    '{24'd1, 24'd0, 21'sd0, 21'sd0, 21'sd1000, 21'sd0, 21'sd5, 0, 48'd0},
    '{24'd2, 24'd1, 21'sd3, -21'sd20, 21'sd20, -21'sd8, 21'sd14, 0, 48'd0},
    '{24'd500, 24'd0, -21'sd5, -21'sd1048576, 21'sd1048575, -21'sd30, -21'sd2, 0, 48'd0},
    '{24'hFFFFFF, 24'd0, 21'sd1048575, -21'sd1048576, 21'sd1048575, -21'sd1048576,
      21'sd1048575, 0, 48'd0},
    '{24'd100, 24'd99, -21'sd1048576, 21'sd1048575, -21'sd1048576, -21'sd1048576,
      21'sd1048575, 0, 48'd0}
  };

  // result check
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (charge_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected pad charge %0d", out_pad_charge);
      end else begin
        want = charge_q.pop_front();
        if (out_pad_charge !== want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("pad charge mismatch: expected %0d, got %0d",
                     $signed(want), out_pad_charge);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    fill_lut();
    m_rate = '0; m_wsq = '0; m_norm = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    // sigma about ten micrometres for small elapsed times
    set_regs(32'd0, 32'd100, 32'd1 << 24);
    foreach (dir_tab[i]) send(dir_tab[i]);
    drain();

    // zero spread, then extremes, then zero charge norm, then random settings
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(32'd0, 32'd0, 32'd1 << 24);
        1: set_regs(32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF);
        2: set_regs(32'd1 << 16, 32'd0, 32'd0);
        default: set_regs($urandom >> $urandom_range(0, 31),
                          $urandom >> $urandom_range(8, 31),
                          $urandom >> $urandom_range(0, 31));
      endcase
      if (ph == 7) idling = 1'b0;
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        send(rand_req());
        sent++;
      end
      drain();
    end

    repeat (PIPE_DEPTH + 10) @(negedge clk);
    if (errors == 0 && charge_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
